FILE: src/mst_pkg.sv
// shared types and constants for the matrix store with transpose and symmetry check
// no dependencies; imported by mst_walk and matrix_store_transpose_symmetry_core
`timescale 1ns / 1ps

package mst_pkg;

  localparam int DIM_W = 11;
  localparam int IDX_W = 10;
  localparam int OP_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int VALUE_PORT_W = 64;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_XPOSE = 3'd3;
  localparam logic [OP_W-1:0] OP_SYM   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COLS = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SHAPE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_EXEC,
    ST_CLEAR,
    ST_XPOSE,
    ST_XTAIL,
    ST_SYM,
    ST_STAIL,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // controls for the address walker
  typedef struct packed {
    logic start;
    logic step;
    logic sym;
  } walk_ctl_t;

endpackage

FILE: src/mst_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mst_walk.sv
// nested row/column address walker shared by clear, transpose and symmetry check
// linear mode: a = r*C+c, b = c*R+r; sym mode (lower triangle): a = r*n+c, b = c*n+r
// depends on mst_pkg
`timescale 1ns / 1ps

module mst_walk #(
  parameter int AW = 10
) (
  input  logic                     clk,
  input  mst_pkg::walk_ctl_t       ctl,
  input  logic [mst_pkg::DIM_W-1:0] rows_in,
  input  logic [mst_pkg::DIM_W-1:0] cols_in,
  output logic [AW-1:0]            addr_a,
  output logic [AW-1:0]            addr_b,
  output logic                     last
);

  import mst_pkg::*;

  localparam int SW = ((AW > DIM_W) ? AW : DIM_W) + 1;

  logic [DIM_W-1:0] r;
  logic [DIM_W-1:0] c;
  logic [DIM_W-1:0] nrows;
  logic [DIM_W-1:0] ncols;
  logic             sym;
  logic [AW-1:0]    a;
  logic [AW-1:0]    a_row;
  logic [AW-1:0]    b;
  logic [SW-1:0]    a_row_adv;
  logic [SW-1:0]    b_adv;
  logic             inner_last;

  assign a_row_adv = SW'(a_row) + SW'(ncols);
  assign b_adv     = SW'(b) + SW'(nrows);

  // sym walks only c < r
  assign inner_last = sym ? (c == r - DIM_W'(1)) : (c == ncols - DIM_W'(1));
  assign last       = inner_last && (r == nrows - DIM_W'(1));

  assign addr_a = a;
  assign addr_b = b;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nrows <= rows_in;
      ncols <= cols_in;
      sym   <= ctl.sym;
      r     <= DIM_W'(ctl.sym);
      c     <= '0;
      a     <= ctl.sym ? AW'(cols_in) : '0;
      a_row <= ctl.sym ? AW'(cols_in) : '0;
      b     <= AW'(ctl.sym);
    end else if (ctl.step) begin
      if (!inner_last) begin
        c <= c + DIM_W'(1);
        a <= a + AW'(1);
        b <= b_adv[AW-1:0];
      end else begin
        r     <= r + DIM_W'(1);
        c     <= '0;
        a     <= a_row_adv[AW-1:0];
        a_row <= a_row_adv[AW-1:0];
        b     <= AW'(r + DIM_W'(1));
      end
    end
  end

endmodule

FILE: src/matrix_store_transpose_symmetry_core.sv
// dense row-major matrix store: clear, element write/read, in-place transpose,
// symmetry check. depends on mst_pkg, mst_ram, mst_walk.
//
// in channel (in_valid/in_ready) takes one beat per operation: op, row_index,
// col_index, write_value. out channel (out_valid/out_ready) returns one beat per
// operation with read_value, is_symmetric, status and the shape afterwards.
// cfg channel (cfg_valid/cfg_ready, always ready) writes initial_rows (index 0)
// or initial_cols (index 1); other indexes are dropped. the shape is taken on clear.
// one operation at a time; in_ready is high only while no operation is in work.
// each operation runs from the input beat through multiply, execute and done;
// read adds a read wait, and clear and transpose walk the n = rows*cols elements
// one per cycle through the address walker and the single ram port. symmetry on
// a square matrix stops at the first mismatch (two reads per mirrored pair).
// the next beat is taken the cycle after the result loads into the output
// register; a stalled receiver holds the block in its final step until the
// output register frees. the store is two ram banks; transpose copies into the
// idle bank and swaps. after reset an init pass zeroes the single 1x1 entry
// before in_ready rises.
`timescale 1ns / 1ps

module matrix_store_transpose_symmetry_core #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mst_pkg::OP_W-1:0]         op,
  input  logic [mst_pkg::IDX_W-1:0]        row_index,
  input  logic [mst_pkg::IDX_W-1:0]        col_index,
  input  logic [mst_pkg::VALUE_PORT_W-1:0] write_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mst_pkg::VALUE_PORT_W-1:0] read_value,
  output logic                             is_symmetric,
  output mst_pkg::status_t                 status,
  output logic [mst_pkg::DIM_W-1:0]        rows_now,
  output logic [mst_pkg::DIM_W-1:0]        cols_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mst_pkg::DIM_W-1:0]        cfg_data
);

  import mst_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int PW = 2 * DIM_W;

  state_t state;
  state_t state_next;

  logic [DIM_W-1:0]      init_rows;
  logic [DIM_W-1:0]      init_cols;
  logic [DIM_W-1:0]      rows;
  logic [DIM_W-1:0]      cols;
  logic                  bank;
  logic                  pend;
  logic                  ph;

  logic [OP_W-1:0]       op_q;
  logic [IDX_W-1:0]      row_q;
  logic [IDX_W-1:0]      col_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [PW-1:0]         prod;
  logic                  oor;
  logic [VALUE_BITS-1:0] res_rd;
  logic                  res_sym;
  status_t               res_status;
  logic [VALUE_BITS-1:0] hold;
  logic [AW-1:0]         pb;
  logic [VALUE_BITS-1:0] out_rd;

  logic [DIM_W-1:0]      mul_a;
  logic [DIM_W-1:0]      mul_b;
  logic [PW:0]           idx_sum;
  logic [AW-1:0]         idx;
  logic                  clr_bad;
  logic                  sym_mis;
  logic                  out_load;

  walk_ctl_t             walk_ctl;
  logic [DIM_W-1:0]      walk_rows;
  logic [DIM_W-1:0]      walk_cols;
  logic [AW-1:0]         walk_a;
  logic [AW-1:0]         walk_b;
  logic                  walk_last;

  logic                  act_we;
  logic [AW-1:0]         act_waddr;
  logic [VALUE_BITS-1:0] act_wdata;
  logic [AW-1:0]         act_raddr;
  logic                  oth_we;
  logic [AW-1:0]         oth_waddr;
  logic [VALUE_BITS-1:0] oth_wdata;

  logic                  we0;
  logic                  we1;
  logic [AW-1:0]         waddr0;
  logic [AW-1:0]         waddr1;
  logic [VALUE_BITS-1:0] wdata0;
  logic [VALUE_BITS-1:0] wdata1;
  logic [VALUE_BITS-1:0] rdata0;
  logic [VALUE_BITS-1:0] rdata1;
  logic [VALUE_BITS-1:0] rd_data;

  // shared multiplier: clear shape size or element row offset
  assign mul_a   = (op_q == OP_CLEAR) ? init_rows : DIM_W'(row_q);
  assign mul_b   = (op_q == OP_CLEAR) ? init_cols : cols;
  assign idx_sum = (PW + 1)'(prod) + (PW + 1)'(col_q);
  assign idx     = idx_sum[AW-1:0];
  assign clr_bad = (init_rows == '0) || (init_cols == '0) || (prod > PW'(MAX_ELEMENTS));
  assign rd_data = bank ? rdata1 : rdata0;
  assign sym_mis = (rd_data != hold);

  assign cfg_ready = 1'b1;

  mst_walk #(
    .AW(AW)
  ) u_walk (
    .clk     (clk),
    .ctl     (walk_ctl),
    .rows_in (walk_rows),
    .cols_in (walk_cols),
    .addr_a  (walk_a),
    .addr_b  (walk_b),
    .last    (walk_last)
  );

  // active bank holds the matrix, the other one takes the transpose copy
  assign we0    = bank ? oth_we    : act_we;
  assign waddr0 = bank ? oth_waddr : act_waddr;
  assign wdata0 = bank ? oth_wdata : act_wdata;
  assign we1    = bank ? act_we    : oth_we;
  assign waddr1 = bank ? act_waddr : oth_waddr;
  assign wdata1 = bank ? act_wdata : oth_wdata;

  mst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (act_raddr),
    .rdata (rdata0)
  );

  mst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .raddr (act_raddr),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    walk_ctl   = '0;
    walk_rows  = rows;
    walk_cols  = cols;
    act_we     = 1'b0;
    act_waddr  = idx;
    act_wdata  = val_q;
    act_raddr  = idx;
    oth_we     = 1'b0;
    oth_waddr  = pb;
    oth_wdata  = rd_data;
    unique case (state)
      ST_INIT: begin
        // 1x1 shape after reset: only entry 0 is visible
        act_we     = 1'b1;
        act_waddr  = '0;
        act_wdata  = '0;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        unique case (op_q)
          OP_CLEAR: begin
            if (!clr_bad) begin
              walk_ctl.start = 1'b1;
              walk_rows      = init_rows;
              walk_cols      = init_cols;
              state_next     = ST_CLEAR;
            end
          end
          OP_WRITE: begin
            act_we = !oor;
          end
          OP_READ: begin
            if (!oor) begin
              state_next = ST_RDWAIT;
            end
          end
          OP_XPOSE: begin
            walk_ctl.start = 1'b1;
            state_next     = ST_XPOSE;
          end
          OP_SYM: begin
            if (rows == cols && rows != DIM_W'(1)) begin
              walk_ctl.start = 1'b1;
              walk_ctl.sym   = 1'b1;
              walk_cols      = rows;
              state_next     = ST_SYM;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: begin
        act_we        = 1'b1;
        act_waddr     = walk_a;
        act_wdata     = '0;
        walk_ctl.step = 1'b1;
        if (walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_XPOSE: begin
        // read source now, write previous beat's word to its mirrored slot
        act_raddr     = walk_a;
        walk_ctl.step = 1'b1;
        oth_we        = pend;
        if (walk_last) begin
          state_next = ST_XTAIL;
        end
      end
      ST_XTAIL: begin
        oth_we     = 1'b1;
        state_next = ST_DONE;
      end
      ST_SYM: begin
        if (!ph) begin
          act_raddr = walk_a;
          if (pend && sym_mis) begin
            state_next = ST_DONE;
          end
        end else begin
          act_raddr     = walk_b;
          walk_ctl.step = 1'b1;
          if (walk_last) begin
            state_next = ST_STAIL;
          end
        end
      end
      ST_STAIL: begin
        state_next = ST_DONE;
      end
      ST_RDWAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_rows <= DIM_W'(1);
      init_cols <= DIM_W'(1);
      rows      <= DIM_W'(1);
      cols      <= DIM_W'(1);
      bank      <= 1'b0;
      pend      <= 1'b0;
      ph        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_INIT_ROWS) begin
          init_rows <= cfg_data;
        end else if (cfg_index == REG_INIT_COLS) begin
          init_cols <= cfg_data;
        end
      end
      if (state == ST_EXEC) begin
        pend <= 1'b0;
        ph   <= 1'b0;
        if (op_q == OP_CLEAR && !clr_bad) begin
          rows <= init_rows;
          cols <= init_cols;
        end
      end
      if (state == ST_XPOSE) begin
        pend <= 1'b1;
      end
      if (state == ST_XTAIL) begin
        bank <= ~bank;
        rows <= cols;
        cols <= rows;
      end
      if (state == ST_SYM) begin
        ph <= ~ph;
        if (ph) begin
          pend <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q  <= op;
      row_q <= row_index;
      col_q <= col_index;
      val_q <= write_value[VALUE_BITS-1:0];
    end
    if (state == ST_MUL) begin
      prod       <= mul_a * mul_b;
      oor        <= (DIM_W'(row_q) >= rows) || (DIM_W'(col_q) >= cols);
      res_rd     <= '0;
      res_sym    <= 1'b0;
      res_status <= STATUS_OK;
    end
    if (state == ST_EXEC) begin
      if (op_q == OP_CLEAR && clr_bad) begin
        res_status <= STATUS_SHAPE;
      end
      if ((op_q == OP_WRITE || op_q == OP_READ) && oor) begin
        res_status <= STATUS_RANGE;
      end
      if (op_q == OP_SYM && rows == cols && rows == DIM_W'(1)) begin
        res_sym <= 1'b1;
      end
    end
    if (state == ST_XPOSE) begin
      pb <= walk_b;
    end
    if (state == ST_SYM && ph) begin
      hold <= rd_data;
    end
    if (state == ST_STAIL) begin
      res_sym <= !sym_mis;
    end
    if (state == ST_RDWAIT) begin
      res_rd <= rd_data;
    end
    if (out_load) begin
      out_rd       <= res_rd;
      is_symmetric <= res_sym;
      status       <= res_status;
      rows_now     <= rows;
      cols_now     <= cols;
    end
  end

  assign read_value = VALUE_PORT_W'(out_rd);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an operation is in work");

  a_sym_square: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_symmetric) |-> (status == STATUS_OK && rows_now == cols_now))
    else $error("symmetric result on a non-square or failed operation");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_value != '0) |-> (status == STATUS_OK && !is_symmetric))
    else $error("read data returned with a failing status");

  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XTAIL) |=> (bank != $past(bank)))
    else $error("transpose finished without swapping banks");

  a_shape_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (32'(rows) * 32'(cols) <= 32'(MAX_ELEMENTS)))
    else $error("current shape exceeds the store");

endmodule
